// File: src/rme_pkg.sv
// shared types and constants for the rsa modular exponentiation block
// no dependencies
package rme_pkg;

  localparam int RME_WIDTH = 32;

  localparam logic [63:0] DEF_PUBLIC_EXP  = 64'd65537;
  localparam logic [63:0] DEF_PRIVATE_EXP = 64'd1;
  localparam logic [63:0] DEF_MODULUS     = 64'd2;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PUBLIC_EXP  = 2'd0,
    REG_PRIVATE_EXP = 2'd1,
    REG_MODULUS     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_SQUARE = 2'd1,
    OP_MULT   = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_t op;
    logic    next_bit;
    logic    capture;
  } rme_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_bit;
    logic last_bit;
  } rme_status_t;

endpackage

// File: src/rme_in_if.sv
// input channel: message and operation code with valid/ready
// depends on rme_pkg
interface rme_in_if import rme_pkg::*; #(
  parameter int WIDTH = RME_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] message;
  logic             func;

  modport source (output valid, output message, output func, input ready);
  modport sink   (input valid, input message, input func, output ready);
endinterface

// File: src/rme_out_if.sv
// output channel: exponentiation result with valid/ready
// depends on rme_pkg
interface rme_out_if import rme_pkg::*; #(
  parameter int WIDTH = RME_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// File: src/rme_mulmod.sv
// iterative shift-add modular multiplier, one multiplier bit per cycle
// depends on rme_pkg
module rme_mulmod import rme_pkg::*; #(
  parameter int WIDTH = RME_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] n,
  output logic             done,
  output logic [WIDTH-1:0] p
);

  localparam int CW = $clog2(WIDTH);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] xr;
  logic [WIDTH-1:0] yr;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] step;

  // (a + b) mod m for a, b below m
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WIDTH-1:0];
  endfunction

  always_comb begin
    dbl  = add_mod(acc, acc, n);
    step = yr[WIDTH-1] ? add_mod(dbl, xr, n) : dbl;
  end

  assign done = busy && (cnt == '0);
  assign p    = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CW'(WIDTH - 1);
      xr  <= x;
      yr  <= y;
      acc <= '0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      yr  <= yr << 1;
      acc <= step;
    end
  end

endmodule

// File: src/rme_datapath.sv
// operand registers, exponent shifter and result register around the multiplier
// depends on rme_pkg and rme_mulmod
module rme_datapath import rme_pkg::*; #(
  parameter int WIDTH = RME_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  rme_cmd_t         cmd,
  output rme_status_t      status,
  input  logic [WIDTH-1:0] message,
  input  logic             func,
  input  logic [WIDTH-1:0] public_exponent,
  input  logic [WIDTH-1:0] private_exponent,
  input  logic [WIDTH-1:0] modulus,
  output logic [WIDTH-1:0] result
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] expo;
  logic [CW-1:0]    bitcnt;
  logic [WIDTH-1:0] one_mod;
  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic [WIDTH-1:0] mul_p;
  logic             mul_done;

  assign one_mod = (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);

  always_comb begin
    unique case (cmd.op)
      OP_REDUCE: begin
        mul_x = one_mod;
        mul_y = base;
      end
      OP_SQUARE: begin
        mul_x = acc;
        mul_y = acc;
      end
      OP_MULT: begin
        mul_x = acc;
        mul_y = base;
      end
      default: begin
        mul_x = acc;
        mul_y = acc;
      end
    endcase
  end

  rme_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .n     (modulus),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign status.mul_done = mul_done;
  assign status.exp_bit  = expo[WIDTH-1];
  assign status.last_bit = (bitcnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base   <= message;
      expo   <= func ? private_exponent : public_exponent;
      acc    <= one_mod;
      bitcnt <= CW'(WIDTH - 1);
    end else begin
      if (mul_done) begin
        if (cmd.op == OP_REDUCE) begin
          base <= mul_p;
        end else begin
          acc <= mul_p;
        end
      end
      if (cmd.next_bit) begin
        expo   <= expo << 1;
        bitcnt <= bitcnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      result <= (modulus == '0) ? '0 : acc;
    end
  end

endmodule

// File: src/rme_ctrl.sv
// sequencer for reduction and square-and-multiply, plus output valid
// depends on rme_pkg
module rme_ctrl import rme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output rme_cmd_t    cmd,
  input  rme_status_t status
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_RED_GO   = 8'b0000_0010,
    S_RED_WAIT = 8'b0000_0100,
    S_SQ_GO    = 8'b0000_1000,
    S_SQ_WAIT  = 8'b0001_0000,
    S_MUL_GO   = 8'b0010_0000,
    S_MUL_WAIT = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = OP_SQUARE;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RED_GO;
        end
      end
      S_RED_GO: begin
        cmd.op        = OP_REDUCE;
        cmd.mul_start = 1'b1;
        state_next    = S_RED_WAIT;
      end
      S_RED_WAIT: begin
        cmd.op = OP_REDUCE;
        if (status.mul_done) begin
          state_next = S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (status.mul_done) begin
          if (status.exp_bit) begin
            state_next = S_MUL_GO;
          end else begin
            cmd.next_bit = 1'b1;
            state_next   = status.last_bit ? S_DONE : S_SQ_GO;
          end
        end
      end
      S_MUL_GO: begin
        cmd.op        = OP_MULT;
        cmd.mul_start = 1'b1;
        state_next    = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        cmd.op = OP_MULT;
        if (status.mul_done) begin
          cmd.next_bit = 1'b1;
          state_next   = status.last_bit ? S_DONE : S_SQ_GO;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.mul_done |-> (state == S_RED_WAIT || state == S_SQ_WAIT ||
                         state == S_MUL_WAIT))
    else $error("multiplier finished outside a wait state");

  a_accept_starts_reduce: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_RED_GO))
    else $error("accepted beat did not start reduction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_valid || out_ready))
    else $error("result captured over a pending beat");

  a_start_idle_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |=> !status.mul_done)
    else $error("multiplier finished right after start");
`endif

endmodule

// File: src/rsa_modular_exponentiation.sv
// rsa modular exponentiation: configuration registers, sequencer and datapath
// a beat is first reduced mod the modulus; then each exponent bit, msb first,
// takes a square and, if set, a multiply on the bit-serial multiplier
// one beat at a time; the next beat is taken only after the result is registered
// reset (rst, synchronous): exponents and modulus to their defaults, no beat pending
// depends on rme_pkg, rme_in_if, rme_out_if, rme_ctrl, rme_datapath
module rsa_modular_exponentiation import rme_pkg::*; #(
  parameter int WIDTH = RME_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  rme_in_if.sink               in,
  rme_out_if.source            out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH-1:0]     cfg_data
);

  logic [WIDTH-1:0] public_exponent;
  logic [WIDTH-1:0] private_exponent;
  logic [WIDTH-1:0] modulus;
  rme_cmd_t         cmd;
  rme_status_t      status;

  always_ff @(posedge clk) begin
    if (rst) begin
      public_exponent  <= DEF_PUBLIC_EXP[WIDTH-1:0];
      private_exponent <= DEF_PRIVATE_EXP[WIDTH-1:0];
      modulus          <= DEF_MODULUS[WIDTH-1:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PUBLIC_EXP:  public_exponent  <= cfg_data;
        REG_PRIVATE_EXP: private_exponent <= cfg_data;
        REG_MODULUS:     modulus          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .cmd       (cmd),
    .status    (status)
  );

  rme_datapath #(.WIDTH(WIDTH)) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .message          (in.message),
    .func             (in.func),
    .public_exponent  (public_exponent),
    .private_exponent (private_exponent),
    .modulus          (modulus),
    .result           (out.result)
  );

endmodule
